[design/serial_frame_register_access_assert.svh]
// Assertion macros for the serial frame register access checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SERIAL_FRAME_REGISTER_ACCESS_ASSERT_SVH
`define SERIAL_FRAME_REGISTER_ACCESS_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SFRA_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("sfra assertion failed");

// Condition implies consequence in the next cycle.
`define SFRA_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("sfra assertion failed");

`endif

[design/sfra_pkg.sv]
// Shared types and constants for the serial frame register access block.
// No dependencies.
`default_nettype none
package sfra_pkg;

  localparam int unsigned WINDOW_WORDS = 31;
  localparam int unsigned IDX_W        = $clog2(WINDOW_WORDS);
  localparam int unsigned WORD_W       = 16;

  localparam logic [15:0] WINDOW_BASE = 16'h0BB0;
  localparam logic [15:0] WINDOW_SPAN = 16'(2 * WINDOW_WORDS);
  localparam logic [15:0] SWITCH_ADDR = 16'h0BE4;

  localparam logic [7:0] ACK_BYTE = 8'hAA;
  localparam logic [7:0] ACK_TAIL = 8'h55;
  localparam logic [7:0] OP_READ  = 8'h01;
  localparam logic [7:0] OP_WRITE = 8'h00;
  localparam logic [7:0] SW_ON    = 8'h01;
  localparam logic [7:0] SW_OFF   = 8'h00;

  localparam logic [2:0] POS_FIRST_KEPT = 3'd1;
  localparam logic [2:0] POS_LAST_KEPT  = 3'd5;
  localparam logic [2:0] POS_DECODE     = 3'd6;
  localparam logic [2:0] POS_LAST       = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       switch_position;
    logic       softstart_pulse;
    logic       reference_clear_pulse;
  } result_t;

endpackage
`default_nettype wire

[design/sfra_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sfra_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[design/serial_frame_register_access.sv]
// Serial frame register access: 8-byte command frames, echo, decode and reply.
// Depends on sfra_pkg and sfra_ram.
//
// Each received byte gives one result word. Byte 6 decodes the frame; for a read
// of the window the result comes from the ST_READ state, after the registered read
// of the 31 x 16 word store RAM, and no new byte is taken in that state. A word
// that was never written reads as zero through a per-entry written flag, so no
// clearing pass runs after reset. A result waits in an output register, and the
// next byte is taken in the same cycle that register is emptied.
`default_nettype none
module serial_frame_register_access
  import sfra_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            tx_valid_o,
  output logic      [7:0] tx_byte_o,
  output logic            switch_position_o,
  output logic            softstart_pulse_o,
  output logic            reference_clear_pulse_o
);

  state_e             state_q, state_d;
  logic [2:0]         pos_q;
  logic [7:0]         frame_q [1:5];
  logic [7:0]         held_q, held_d;
  logic               switch_q, switch_d;
  logic [WINDOW_WORDS-1:0] written_q;
  logic               rd_hit_q;
  logic               out_valid_q;
  result_t            res_q, res_d;
  logic               load_out;

  logic               accept, out_free;
  logic [15:0]        addr, diff;
  logic [7:0]         op;
  logic               in_win;
  logic [IDX_W-1:0]   idx;
  logic               ram_we, ram_re;
  logic [WORD_W-1:0]  ram_rdata, rd_word;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign addr   = {frame_q[4], frame_q[3]};
  assign op     = frame_q[5];
  assign diff   = addr - WINDOW_BASE;
  assign in_win = !addr[0] && (addr >= WINDOW_BASE) && (diff < WINDOW_SPAN);
  assign idx    = diff[IDX_W:1];
  assign rd_word = rd_hit_q ? ram_rdata : '0;

  sfra_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WINDOW_WORDS)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx),
    .wdata_i({frame_q[2], frame_q[1]}),
    .re_i   (ram_re),
    .raddr_i(idx),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    switch_d = switch_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    load_out = 1'b0;
    res_d    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load_out       = 1'b1;
          res_d.tx_valid = 1'b1;
          case (pos_q)
            POS_DECODE: begin
              if (!in_win) begin
                res_d.tx_byte = ACK_BYTE;
                held_d        = ACK_TAIL;
              end else if (op == OP_READ) begin
                load_out = 1'b0;
                ram_re   = 1'b1;
                state_d  = ST_READ;
              end else if (op == OP_WRITE) begin
                if (addr == SWITCH_ADDR) begin
                  if (frame_q[1] == SW_ON) begin
                    switch_d                    = 1'b1;
                    res_d.softstart_pulse       = 1'b1;
                    res_d.reference_clear_pulse = 1'b1;
                  end else if (frame_q[1] == SW_OFF) begin
                    switch_d = 1'b0;
                  end
                end else begin
                  ram_we = 1'b1;
                end
                res_d.tx_byte = ACK_BYTE;
                held_d        = ACK_TAIL;
              end else begin
                res_d.tx_valid = 1'b0;
              end
            end
            POS_LAST: begin
              res_d.tx_byte = held_q;
            end
            default: begin
              res_d.tx_byte = rx_byte_i;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          load_out       = 1'b1;
          res_d.tx_valid = 1'b1;
          res_d.tx_byte  = rd_word[7:0];
          held_d         = rd_word[15:8];
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    res_d.switch_position = switch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      held_q      <= '0;
      switch_q    <= 1'b0;
      written_q   <= '0;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      switch_q <= switch_d;
      if (accept) begin
        pos_q <= pos_q + 3'd1;
      end
      if (ram_we) begin
        written_q[idx] <= 1'b1;
      end
      if (ram_re) begin
        rd_hit_q <= written_q[idx];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos_q >= POS_FIRST_KEPT && pos_q <= POS_LAST_KEPT) begin
      frame_q[pos_q] <= rx_byte_i;
    end
    if (load_out) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign tx_valid_o              = res_q.tx_valid;
  assign tx_byte_o               = res_q.tx_byte;
  assign switch_position_o       = res_q.switch_position;
  assign softstart_pulse_o       = res_q.softstart_pulse;
  assign reference_clear_pulse_o = res_q.reference_clear_pulse;

endmodule
`default_nettype wire

[design/sfra_checker.sv]
// Port-level checks for serial_frame_register_access, bound to the top level.
// Depends on sfra_pkg and serial_frame_register_access_assert.svh.
`default_nettype none
`include "serial_frame_register_access_assert.svh"
module sfra_checker
  import sfra_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       tx_valid_o,
  input wire logic [7:0] tx_byte_o,
  input wire logic       switch_position_o,
  input wire logic       softstart_pulse_o,
  input wire logic       reference_clear_pulse_o
);

  `SFRA_ASSERT_NEXT(a_hold_stalled, out_valid_o && out_stall_i, out_valid_o && $stable(tx_byte_o))
  `SFRA_ASSERT_NOW(a_pulses_pair, out_valid_o, softstart_pulse_o == reference_clear_pulse_o)
  `SFRA_ASSERT_NOW(a_pulse_ack, out_valid_o && softstart_pulse_o, switch_position_o && tx_valid_o && tx_byte_o == ACK_BYTE)
  `SFRA_ASSERT_NOW(a_silent_zero, out_valid_o && !tx_valid_o, tx_byte_o == 8'h00)

endmodule

bind serial_frame_register_access sfra_checker u_sfra_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .tx_valid_o             (tx_valid_o),
  .tx_byte_o              (tx_byte_o),
  .switch_position_o      (switch_position_o),
  .softstart_pulse_o      (softstart_pulse_o),
  .reference_clear_pulse_o(reference_clear_pulse_o)
);
`default_nettype wire

[bench/serial_frame_register_access_tb.sv]
// Testbench for serial_frame_register_access: drives command frames byte by byte and checks
// every reply word against a fixed table or a cycle-free predictor of decoder and word store.
// Depends on sfra_pkg and the serial_frame_register_access RTL.
`default_nettype none
module serial_frame_register_access_tb;
  import sfra_pkg::*;

  typedef struct packed {
    logic [7:0] rx;
    result_t    reply;
  } stim_row_t;

  localparam int unsigned DIR_ROWS     = 24;
  localparam int unsigned RAND_FRAMES  = 100;
  localparam int unsigned CALM_FIRST   = 40;
  localparam int unsigned CALM_LAST    = 55;
  localparam int unsigned DRAIN_FRAME  = 70;
  localparam logic [15:0] WINDOW_LAST  = WINDOW_BASE + WINDOW_SPAN - 16'd2;

  // Write 0xFFFF to the window base, turn the switch on, read the window base back.
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'h00, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0}},
    '{8'hB0, '{1'b1, 8'hB0, 1'b0, 1'b0, 1'b0}},
    '{8'h0B, '{1'b1, 8'h0B, 1'b0, 1'b0, 1'b0}},
    '{8'h00, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, '{1'b1, ACK_BYTE, 1'b0, 1'b0, 1'b0}},
    '{8'h80, '{1'b1, ACK_TAIL, 1'b0, 1'b0, 1'b0}},
    '{8'h7F, '{1'b1, 8'h7F, 1'b0, 1'b0, 1'b0}},
    '{8'h01, '{1'b1, 8'h01, 1'b0, 1'b0, 1'b0}},
    '{8'h00, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'hE4, '{1'b1, 8'hE4, 1'b0, 1'b0, 1'b0}},
    '{8'h0B, '{1'b1, 8'h0B, 1'b0, 1'b0, 1'b0}},
    '{8'h00, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h01, '{1'b1, ACK_BYTE, 1'b1, 1'b1, 1'b1}},
    '{8'hFE, '{1'b1, ACK_TAIL, 1'b1, 1'b0, 1'b0}},
    '{8'h00, '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'h00, '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'h00, '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'hB0, '{1'b1, 8'hB0, 1'b1, 1'b0, 1'b0}},
    '{8'h0B, '{1'b1, 8'h0B, 1'b1, 1'b0, 1'b0}},
    '{8'h01, '{1'b1, 8'h01, 1'b1, 1'b0, 1'b0}},
    '{8'h00, '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0}},
    '{8'h00, '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0}}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic       switch_position_o;
  logic       softstart_pulse_o;
  logic       reference_clear_pulse_o;

  logic [2:0]  frame_pos;
  logic [7:0]  frame_buf [8];
  logic [7:0]  kept_byte;
  logic [15:0] word_mem [WINDOW_WORDS];
  logic        switch_on;

  result_t pending_replies [$];
  bit      calm;
  int      n_errors;
  int      n_sent;
  int      n_checked;
  int      n_reads;
  int      n_writes;
  int      n_switch_on;

  serial_frame_register_access i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .rx_byte_i              (rx_byte_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .tx_valid_o             (tx_valid_o),
    .tx_byte_o              (tx_byte_o),
    .switch_position_o      (switch_position_o),
    .softstart_pulse_o      (softstart_pulse_o),
    .reference_clear_pulse_o(reference_clear_pulse_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic result_t predict_reply(input logic [7:0] rx);
    result_t     r;
    logic [15:0] data;
    logic [15:0] addr;
    logic [7:0]  op;
    int          idx;
    r = '0;
    frame_buf[frame_pos] = rx;
    r.tx_valid = 1'b1;
    if (frame_pos < POS_DECODE) begin
      r.tx_byte = rx;
    end else if (frame_pos == POS_LAST) begin
      r.tx_byte = kept_byte;
    end else begin
      data = {frame_buf[2], frame_buf[1]};
      addr = {frame_buf[4], frame_buf[3]};
      op   = frame_buf[5];
      idx  = int'((addr - WINDOW_BASE) >> 1);
      if (addr[0] || addr < WINDOW_BASE || addr >= WINDOW_BASE + WINDOW_SPAN) begin
        kept_byte = ACK_TAIL;
        r.tx_byte = ACK_BYTE;
      end else if (op == OP_READ) begin
        n_reads++;
        r.tx_byte = word_mem[idx][7:0];
        kept_byte = word_mem[idx][15:8];
      end else if (op == OP_WRITE) begin
        n_writes++;
        if (addr == SWITCH_ADDR) begin
          if (frame_buf[1] == SW_ON) begin
            switch_on = 1'b1;
            r.softstart_pulse = 1'b1;
            r.reference_clear_pulse = 1'b1;
            n_switch_on++;
          end else if (frame_buf[1] == SW_OFF) begin
            switch_on = 1'b0;
          end
        end else begin
          word_mem[idx] = data;
        end
        kept_byte = ACK_TAIL;
        r.tx_byte = ACK_BYTE;
      end else begin
        r.tx_valid = 1'b0;
      end
    end
    r.switch_position = switch_on;
    frame_pos = frame_pos + 3'd1;
    return r;
  endfunction

  function automatic logic [63:0] make_frame();
    logic [15:0] addr;
    logic [15:0] data;
    logic [7:0]  op;
    int          pick;
    data = 16'($urandom);
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: addr = WINDOW_BASE + 16'(2 * $urandom_range(0, WINDOW_WORDS - 1));
      3: begin
        addr = SWITCH_ADDR;
        case ($urandom_range(0, 2))
          0: data[7:0] = SW_OFF;
          1: data[7:0] = SW_ON;
          default: data[7:0] = 8'($urandom);
        endcase
      end
      4: addr = WINDOW_LAST;
      5: addr = WINDOW_BASE + 16'(2 * $urandom_range(0, WINDOW_WORDS - 1)) + 16'd1;
      6: begin
        case ($urandom_range(0, 3))
          0: addr = WINDOW_BASE - 16'd2;
          1: addr = WINDOW_BASE - 16'd1;
          2: addr = WINDOW_LAST + 16'd1;
          default: addr = WINDOW_BASE + WINDOW_SPAN;
        endcase
      end
      7: addr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: addr = 16'($urandom);
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      op = OP_WRITE;
    end else if (pick < 17) begin
      op = OP_READ;
    end else begin
      op = 8'($urandom_range(2, 255));
    end
    return {8'($urandom), 8'($urandom), op, addr, data, 8'($urandom)};
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 35);
  endfunction

  task automatic send_word(input logic [7:0] rx, input bit typed, input result_t fixed);
    result_t r;
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= rx;
    @(posedge clk_i iff !in_stall_o);
    r = predict_reply(rx);
    pending_replies.push_back(typed ? fixed : r);
    n_sent++;
  endtask

  task automatic send_frame(input logic [63:0] frame);
    for (int i = 0; i < 8; i++) begin
      send_word(frame[8*i +: 8], 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= take_break();
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        $error("result word with no expectation: tx_byte %02h", tx_byte_o);
        n_errors++;
      end else begin
        want = pending_replies.pop_front();
        n_checked++;
        if (tx_valid_o !== want.tx_valid) begin
          $error("tx_valid: expected %0b, got %0b", want.tx_valid, tx_valid_o);
          n_errors++;
        end
        if (tx_byte_o !== want.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte_o);
          n_errors++;
        end
        if (switch_position_o !== want.switch_position) begin
          $error("switch_position: expected %0b, got %0b", want.switch_position,
                 switch_position_o);
          n_errors++;
        end
        if (softstart_pulse_o !== want.softstart_pulse) begin
          $error("softstart_pulse: expected %0b, got %0b", want.softstart_pulse,
                 softstart_pulse_o);
          n_errors++;
        end
        if (reference_clear_pulse_o !== want.reference_clear_pulse) begin
          $error("reference_clear_pulse: expected %0b, got %0b",
                 want.reference_clear_pulse, reference_clear_pulse_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL serial_frame_register_access");
    $finish;
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    frame_pos   = '0;
    kept_byte   = '0;
    switch_on   = 1'b0;
    for (int i = 0; i < 8; i++) frame_buf[i] = '0;
    for (int i = 0; i < WINDOW_WORDS; i++) word_mem[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DIR_ROWS; k++) begin
      send_word(DIR_TABLE[k].rx, 1'b1, DIR_TABLE[k].reply);
    end

    for (int f = 0; f < RAND_FRAMES; f++) begin
      calm = (f >= CALM_FIRST) && (f < CALM_LAST);
      if (f == DRAIN_FRAME) wait_drained();
      // Keep most frames well formed; the rest is raw noise.
      if ($urandom_range(0, 9) == 0) begin
        send_frame({$urandom, $urandom});
      end else begin
        send_frame(make_frame());
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Ran %0d bytes, checked %0d reply words: %0d window reads, %0d writes,",
             n_sent, n_checked, n_reads, n_writes);
    $display("%0d switch-on commands, plus odd, outside and unknown-operation frames.",
             n_switch_on);
    if (n_errors == 0) begin
      $display("PASS serial_frame_register_access");
    end else begin
      $display("FAIL serial_frame_register_access");
    end
    $finish;
  end

endmodule
`default_nettype wire
